[src/evg_pkg.sv]
`default_nettype none

package evg_pkg;

	// Frame length limit default
	localparam int MAX_FRAME_DEF = 1024;

	// Shared multiplier operand widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Mean absolute value fits 16 bits (at most 32768)
	localparam int QUO_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET     = 3'd4;

	// Register reset values
	localparam logic [15:0] ENERGY_THR_RST = 16'd30;
	localparam logic [30:0] VAR_THR_RST    = 31'd800;
	localparam logic [15:0] SILENCE_RST    = 16'd1000;
	localparam logic [15:0] MIN_SPEECH_RST = 16'd150;
	localparam logic [23:0] BUDGET_RST     = 24'd80000;
	localparam logic [23:0] SES_CNT_MAX    = 24'hFFFFFF;

	// Operands of one multiply step
	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} evg_mul_op_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_F0,
		S_F1,
		S_F2,
		S_F3,
		S_F4,
		S_F5,
		S_F6,
		S_F7,
		S_WAIT,
		S_DEC
	} evg_state_t;

endpackage

`default_nettype wire

[src/evg_mul.sv]
`default_nettype none

module evg_mul (
	input  wire logic                         clk,
	input  wire evg_pkg::evg_mul_op_t         op,
	output logic [evg_pkg::MUL_P_W-1:0]       prod_q
);
	import evg_pkg::*;

	// One 32x16 product per cycle, registered
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
	end

endmodule

`default_nettype wire

[src/evg_div.sv]
`default_nettype none

module evg_div #(
	parameter int DVS_W = 11
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [DVS_W+evg_pkg::QUO_W-2:0] dividend,
	input  wire logic [DVS_W-1:0]                divisor,
	output logic                                 busy,
	output logic [evg_pkg::QUO_W-1:0]            quotient
);
	import evg_pkg::*;

	localparam int DVD_W = DVS_W + QUO_W - 1;
	localparam int CNT_W = $clog2(QUO_W);

	logic [DVD_W-1:0] rem_q;
	logic [DVD_W-1:0] dsr_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             ge;

	assign ge = rem_q >= dsr_q;

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Restoring division, one quotient bit a cycle, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= DVD_W'(divisor) << (QUO_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[src/energy_variance_voice_activity_gate_unit.sv]
// Energy and variance voice activity gate.
// Input channel (in_valid/in_ready) takes one audio sample per item with its
// frame_end, now_ms and session_start flags. Each sample is accepted in S_IDLE,
// which also issues the square to the shared 32x16 multiplier, and is then
// accumulated in S_ACC. A sample that closes a frame (frame_end, or the
// frame reaching MAX_FRAME samples) is followed by an evaluation:
// seven multiplier steps build n*sumsq - sum^2 and thr*n^2, while a 16-step
// restoring divider forms the mean absolute value; the divider sets the
// evaluation's length. The sequencer goes through S_F0 to S_F7, waits in
// S_WAIT for the divider, loads the result register in S_DEC and then
// returns to S_IDLE. in_ready is low in every state but S_IDLE.
// One result item per frame leaves on out_valid/out_ready from an output
// register; the next samples are taken while it waits. A second result
// that finds the register still full holds the sequencer until it drains.
// Once session_done is set, samples are dropped without a result until one
// with session_start. Configuration (cfg_valid/cfg_ready) is always ready.
// Reset puts the registers at their defaults and clears all session state.
`default_nettype none

module energy_variance_voice_activity_gate_unit #(
	parameter int MAX_FRAME = evg_pkg::MAX_FRAME_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [evg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [evg_pkg::CFG_DATA_W-1:0]  cfg_data,
	// samples
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [15:0]              sample,
	input  wire logic                            frame_end,
	input  wire logic [31:0]                     now_ms,
	input  wire logic                            session_start,
	// results
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 frame_is_speech,
	output logic [15:0]                          frame_energy,
	output logic                                 speaking,
	output logic                                 forward_frame,
	output logic                                 valid_speech,
	output logic                                 speech_ended,
	output logic                                 session_done
);
	import evg_pkg::*;

	localparam int CNT_W  = $clog2(MAX_FRAME + 1);
	localparam int SUM_W  = CNT_W + 15;
	localparam int SQ_W   = CNT_W + 30;
	localparam int PROD_W = 2 * CNT_W + 31;

	evg_state_t state_q, state_d;

	// configuration registers
	logic [15:0] ethr_q;
	logic [30:0] vthr_q;
	logic [15:0] sil_q;
	logic [15:0] minsp_q;
	logic [23:0] budget_q;

	// session state
	logic             spk_q, valid_q, ended_q, done_q;
	logic [31:0]      start_t_q, last_t_q;
	logic [SUM_W-1:0] abs_q;
	logic [SQ_W-1:0]  sq_q;
	logic [CNT_W-1:0] frm_cnt_q;
	logic [23:0]      ses_cnt_q;

	// captured sample and evaluation scratch
	logic [15:0]       mag_q;
	logic              fend_q;
	logic [31:0]       now_q;
	logic [PROD_W-1:0] lhs_q, rhs_q;
	logic [31:0]       nn_q;
	logic              var_ok_q;

	// output register
	logic        out_valid_q;
	logic        res_speech_q, res_spk_q, res_fwd_q, res_valid_q, res_ended_q, res_done_q;
	logic [15:0] res_energy_q;

	logic [15:0]        smp_u, mag_in;
	logic               accept, skip, ld_out, div_start, div_busy;
	logic [CNT_W-1:0]   cnt_nx;
	logic               frame_last;
	logic [31:0]        sum32;
	logic [47:0]        sq48;
	logic [MUL_P_W-1:0] prod;
	logic [QUO_W-1:0]   energy;
	evg_mul_op_t        mop;

	logic        speech, spk_on, stop, spk_n, valid_n, ended_n, done_n;
	logic [31:0] start_n, last_n;

	// magnitude of the incoming sample; -32768 maps to 32768
	assign smp_u  = sample;
	assign mag_in = smp_u[15] ? (16'd0 - smp_u) : smp_u;

	assign accept = in_valid && in_ready;
	assign skip   = done_q && !session_start;
	assign cnt_nx = frm_cnt_q + 1'b1;
	assign frame_last = fend_q || (cnt_nx == CNT_W'(MAX_FRAME));
	assign sum32  = 32'(abs_q);
	assign sq48   = 48'(sq_q);

	evg_mul u_mul (
		.clk    (clk),
		.op     (mop),
		.prod_q (prod)
	);

	evg_div #(
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_q),
		.divisor  (frm_cnt_q),
		.busy     (div_busy),
		.quotient (energy)
	);

	// frame decision and hangover
	always_comb begin
		speech  = (energy >= ethr_q) && (spk_q || var_ok_q);
		spk_on  = spk_q || speech;
		start_n = (!spk_q && speech) ? now_q : start_t_q;
		last_n  = speech ? now_q : last_t_q;
		valid_n = valid_q || (spk_on && ((now_q - start_n) >= 32'(minsp_q)));
		stop    = spk_on && !speech && ((now_q - last_n) >= 32'(sil_q));
		spk_n   = spk_on && !stop;
		ended_n = ended_q || stop;
		done_n  = done_q || (stop && valid_n) || (ses_cnt_q >= budget_q);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, multiplier operands, strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		ld_out    = 1'b0;
		mop.a     = 32'(mag_in);
		mop.b     = mag_in;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !skip) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				state_d = frame_last ? S_F0 : S_IDLE;
			end
			S_F0: begin
				div_start = 1'b1;
				mop.a     = sq48[31:0];
				mop.b     = 16'(frm_cnt_q);
				state_d   = S_F1;
			end
			S_F1: begin
				mop.a   = 32'(sq48[47:32]);
				mop.b   = 16'(frm_cnt_q);
				state_d = S_F2;
			end
			S_F2: begin
				mop.a   = sum32;
				mop.b   = sum32[15:0];
				state_d = S_F3;
			end
			S_F3: begin
				mop.a   = sum32;
				mop.b   = sum32[31:16];
				state_d = S_F4;
			end
			S_F4: begin
				mop.a   = 32'(frm_cnt_q);
				mop.b   = 16'(frm_cnt_q);
				state_d = S_F5;
			end
			S_F5: begin
				mop.a   = 32'(vthr_q);
				mop.b   = prod[15:0];
				state_d = S_F6;
			end
			S_F6: begin
				mop.a   = 32'(vthr_q);
				mop.b   = nn_q[31:16];
				state_d = S_F7;
			end
			S_F7: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!div_busy) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (!out_valid_q || out_ready) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ethr_q   <= ENERGY_THR_RST;
			vthr_q   <= VAR_THR_RST;
			sil_q    <= SILENCE_RST;
			minsp_q  <= MIN_SPEECH_RST;
			budget_q <= BUDGET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENERGY_THR: ethr_q   <= cfg_data[15:0];
				REG_VAR_THR:    vthr_q   <= cfg_data[30:0];
				REG_SILENCE:    sil_q    <= cfg_data[15:0];
				REG_MIN_SPEECH: minsp_q  <= cfg_data[15:0];
				REG_BUDGET:     budget_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// session state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spk_q     <= 1'b0;
			valid_q   <= 1'b0;
			ended_q   <= 1'b0;
			done_q    <= 1'b0;
			start_t_q <= '0;
			last_t_q  <= '0;
			abs_q     <= '0;
			sq_q      <= '0;
			frm_cnt_q <= '0;
			ses_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && session_start) begin
						spk_q     <= 1'b0;
						valid_q   <= 1'b0;
						ended_q   <= 1'b0;
						done_q    <= 1'b0;
						start_t_q <= '0;
						last_t_q  <= now_ms;
						abs_q     <= '0;
						sq_q      <= '0;
						frm_cnt_q <= '0;
						ses_cnt_q <= '0;
					end
				end
				S_ACC: begin
					abs_q     <= abs_q + SUM_W'(mag_q);
					sq_q      <= sq_q + SQ_W'(prod[30:0]);
					frm_cnt_q <= cnt_nx;
					if (ses_cnt_q != SES_CNT_MAX) begin
						ses_cnt_q <= ses_cnt_q + 1'b1;
					end
				end
				S_DEC: begin
					if (ld_out) begin
						spk_q     <= spk_n;
						valid_q   <= valid_n;
						ended_q   <= ended_n;
						done_q    <= done_n;
						start_t_q <= start_n;
						last_t_q  <= last_n;
						abs_q     <= '0;
						sq_q      <= '0;
						frm_cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// sample capture and variance terms
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag_in;
			fend_q <= frame_end;
			now_q  <= now_ms;
		end
		case (state_q)
			S_F1:   lhs_q <= PROD_W'(prod);
			S_F2:   lhs_q <= lhs_q + (PROD_W'(prod) << 32);
			S_F3:   rhs_q <= PROD_W'(prod);
			S_F4:   rhs_q <= rhs_q + (PROD_W'(prod) << 16);
			S_F5: begin
				lhs_q <= (lhs_q >= rhs_q) ? (lhs_q - rhs_q) : '0;
				nn_q  <= prod[31:0];
			end
			S_F6:   rhs_q <= PROD_W'(prod);
			S_F7:   rhs_q <= rhs_q + (PROD_W'(prod) << 16);
			S_WAIT: var_ok_q <= lhs_q >= rhs_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			res_speech_q <= speech;
			res_energy_q <= energy;
			res_spk_q    <= spk_n;
			res_fwd_q    <= spk_on;
			res_valid_q  <= valid_n;
			res_ended_q  <= ended_n;
			res_done_q   <= done_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_is_speech = res_speech_q;
	assign frame_energy    = res_energy_q;
	assign speaking        = res_spk_q;
	assign forward_frame   = res_fwd_q;
	assign valid_speech    = res_valid_q;
	assign speech_ended    = res_ended_q;
	assign session_done    = res_done_q;

	// checks
	a_res_from_dec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DEC))
		else $error("result appeared outside frame decision");

	a_frame_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		frm_cnt_q <= CNT_W'(MAX_FRAME))
		else $error("frame sample count beyond limit");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEC |-> !div_busy)
		else $error("decision taken before mean value is ready");

	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done_q && !session_start) |=> state_q == S_IDLE)
		else $error("sample processed after session stop");

endmodule

`default_nettype wire

[test/energy_variance_voice_activity_gate_unit_tb.sv]
`timescale 1ns / 100ps

module energy_variance_voice_activity_gate_unit_tb;
	import evg_pkg::*;

	localparam int FRAME_CAP    = MAX_FRAME_DEF;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 660;
	localparam int PHASES       = 6;

	// one input item
	typedef struct packed {
		logic signed [15:0] smp;
		logic               fe;
		logic [31:0]        now;
		logic               ss;
	} audio_item_t;

	// one result item
	typedef struct packed {
		logic        speech;
		logic [15:0] energy;
		logic        talking;
		logic        fwd;
		logic        valid;
		logic        ended;
		logic        done;
	} gate_verdict_t;

	// directed stimulus row
	typedef struct {
		audio_item_t   item;
		int            reps;
		bit            typed;
		gate_verdict_t want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [15:0]    sample;
	logic                  frame_end;
	logic [31:0]           now_ms;
	logic                  session_start;
	logic                  out_valid;
	logic                  out_ready;
	logic                  frame_is_speech;
	logic [15:0]           frame_energy;
	logic                  speaking;
	logic                  forward_frame;
	logic                  valid_speech;
	logic                  speech_ended;
	logic                  session_done;

	energy_variance_voice_activity_gate_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.frame_end       (frame_end),
		.now_ms          (now_ms),
		.session_start   (session_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_is_speech (frame_is_speech),
		.frame_energy    (frame_energy),
		.speaking        (speaking),
		.forward_frame   (forward_frame),
		.valid_speech    (valid_speech),
		.speech_ended    (speech_ended),
		.session_done    (session_done)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// gate settings as last written
	logic [15:0] thr_energy     = ENERGY_THR_RST;
	logic [30:0] thr_spread     = VAR_THR_RST;
	logic [15:0] hang_ms        = SILENCE_RST;
	logic [15:0] min_talk_ms    = MIN_SPEECH_RST;
	logic [23:0] budget_samples = BUDGET_RST;

	// session state of the gate
	bit              talking;
	bit              talk_valid;
	bit              talk_ended;
	bit              gate_done;
	logic [31:0]     talk_start_ms;
	logic [31:0]     last_voice_ms;
	longint unsigned abs_sum;
	longint unsigned sq_sum;
	int              frame_len;
	logic [23:0]     session_len;

	gate_verdict_t verdicts[$];
	script_row_t   script[$];
	int            mismatches;
	int            taken_items;
	int            stalled_cycles;
	bit            no_idle;
	logic [31:0]   clock_ms;

	// Fold one accepted sample into the gate; returns 1 when it closes a frame.
	// taken is 0 when a stopped session drops the sample.
	function automatic bit fold_sample(input audio_item_t it, output bit taken,
		output gate_verdict_t v);
		int              s;
		longint unsigned n;
		longint unsigned spread;
		longint unsigned floor_v;
		longint unsigned mean;
		logic [31:0]     since;
		bit              speech;
		v = '0;
		taken = 1'b0;
		if (it.ss) begin
			talking = 1'b0;
			talk_valid = 1'b0;
			talk_ended = 1'b0;
			gate_done = 1'b0;
			talk_start_ms = '0;
			last_voice_ms = it.now;
			abs_sum = 0;
			sq_sum = 0;
			frame_len = 0;
			session_len = '0;
		end
		if (gate_done)
			return 1'b0;
		taken = 1'b1;
		s = int'(it.smp);
		if (s < 0)
			s = -s;
		abs_sum += longint'(s);
		sq_sum += longint'(s) * longint'(s);
		frame_len++;
		if (session_len < SES_CNT_MAX)
			session_len++;
		if (!it.fe && frame_len < FRAME_CAP)
			return 1'b0;

		// frame evaluation: mean, exact variance test, hysteresis
		n = longint'(frame_len);
		mean = abs_sum / n;
		spread = (n * sq_sum >= abs_sum * abs_sum) ? n * sq_sum - abs_sum * abs_sum : 0;
		floor_v = longint'(thr_spread) * n * n;
		speech = (mean >= longint'(thr_energy)) && (talking || spread >= floor_v);

		if (!talking && speech) begin
			talking = 1'b1;
			talk_start_ms = it.now;
			last_voice_ms = it.now;
		end
		if (talking) begin
			if (speech)
				last_voice_ms = it.now;
			since = it.now - talk_start_ms;
			if (since >= {16'd0, min_talk_ms})
				talk_valid = 1'b1;
			v.fwd = 1'b1;
			since = it.now - last_voice_ms;
			if (!speech && since >= {16'd0, hang_ms}) begin
				talking = 1'b0;
				talk_ended = 1'b1;
				if (talk_valid)
					gate_done = 1'b1;
			end
		end
		if (session_len >= budget_samples)
			gate_done = 1'b1;
		abs_sum = 0;
		sq_sum = 0;
		frame_len = 0;

		v.speech = speech;
		v.energy = mean[15:0];
		v.talking = talking;
		v.valid = talk_valid;
		v.ended = talk_ended;
		v.done = gate_done;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic signed [15:0] smp, input logic fe,
		input logic [31:0] now, input logic ss, input int reps, input bit typed,
		input gate_verdict_t want);
		script_row_t row;
		row.item = {smp, fe, now, ss};
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endfunction

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string what, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Offer one item and wait for acceptance; typed rows supply the result.
	task automatic send_item(input audio_item_t it, input bit typed,
		input gate_verdict_t want);
		gate_verdict_t v;
		bit            taken;
		int            gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= it.smp;
		frame_end <= it.fe;
		now_ms <= it.now;
		session_start <= it.ss;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (fold_sample(it, taken, v))
			verdicts.push_back(typed ? want : v);
		if (taken)
			taken_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ENERGY_THR: thr_energy = val[15:0];
			REG_VAR_THR:    thr_spread = val[30:0];
			REG_SILENCE:    hang_ms = val[15:0];
			REG_MIN_SPEECH: min_talk_ms = val[15:0];
			REG_BUDGET:     budget_samples = val[23:0];
			default: ;
		endcase
	endtask

	// let every expected result drain and the sequencer go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_phase(input int phase);
		logic [CFG_DATA_W-1:0] e, vt, sl, ms, bg;
		case (phase)
			1: begin
				e = 0; vt = 0; sl = 0; ms = 0; bg = 1;
			end
			2: begin
				e = 32768; vt = 31'd1 << 30; sl = 65535; ms = 65535; bg = 24'hFFFFFF;
			end
			3: begin
				e = 100; vt = 2000; sl = 50; ms = 20; bg = 300;
			end
			4: begin
				e = CFG_DATA_W'($urandom_range(0, 2000));
				vt = CFG_DATA_W'($urandom_range(0, 100000));
				sl = CFG_DATA_W'($urandom_range(0, 3000));
				ms = CFG_DATA_W'($urandom_range(0, 500));
				bg = CFG_DATA_W'($urandom_range(1, 5000));
			end
			default: begin
				e = 20; vt = 400; sl = 200; ms = 100; bg = 1500;
			end
		endcase
		write_reg(REG_ENERGY_THR, e);
		write_reg(REG_VAR_THR, vt);
		write_reg(REG_SILENCE, sl);
		write_reg(REG_MIN_SPEECH, ms);
		write_reg(REG_BUDGET, bg);
		cfg_valid <= 1'b0;
	endtask

	// One frame of random content: speech-like, quiet, steady hum, raw or extreme.
	task automatic play_frame(input bit fresh);
		audio_item_t it;
		int          len, kind, amp, mag, s, r, i;
		r = $urandom_range(0, 299);
		if (r == 0)
			len = FRAME_CAP;
		else if (r < 240)
			len = $urandom_range(1, 12);
		else
			len = $urandom_range(13, 160);
		kind = $urandom_range(0, 99);
		amp = $urandom_range(1, 32768);
		r = $urandom_range(0, 99);
		if (r < 70)
			clock_ms += $urandom_range(0, 60);
		else if (r < 92)
			clock_ms += $urandom_range(61, 400);
		else if (r < 98)
			clock_ms += $urandom_range(401, 3000);
		else
			clock_ms = $urandom;
		for (i = 0; i < len; i++) begin
			if (kind < 40)
				mag = $urandom_range(0, amp);
			else if (kind < 65)
				mag = $urandom_range(0, 40);
			else if (kind < 80)
				mag = amp;
			else if (kind < 95)
				mag = $urandom_range(0, 32768);
			else
				mag = $urandom_range(0, 1) ? 32768 : $urandom_range(0, 1);
			s = $urandom_range(0, 1) ? -mag : mag;
			if (kind >= 95 && $urandom_range(0, 3) == 0)
				s = 32767;
			it.smp = 16'(s);
			// an overlong frame carries no frame end; the cap closes it
			it.fe = (len < FRAME_CAP) && (i == len - 1);
			it.now = clock_ms;
			it.ss = (fresh && i == 0) || ($urandom_range(0, 199) == 0);
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic random_traffic(input int quota);
		audio_item_t junk;
		int          goal;
		bit          fresh;
		goal = taken_items + quota;
		fresh = 1'b1;
		while (taken_items < goal) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			if (gate_done) begin
				// stray samples after stop are dropped
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						junk = {16'($urandom), 1'($urandom), $urandom, 1'b0};
						send_item(junk, 1'b0, '0);
					end
				end
				fresh = 1'b1;
			end else if ($urandom_range(0, 24) == 0) begin
				fresh = 1'b1;
			end
			if (fresh && $urandom_range(0, 3) == 0)
				clock_ms = $urandom;
			play_frame(fresh);
			fresh = 1'b0;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		gate_verdict_t want;
		if (out_valid && out_ready) begin
			if (verdicts.size() == 0) begin
				$display("%0t: result with none expected, energy %0d", $time, frame_energy);
				mismatches++;
			end else begin
				want = verdicts.pop_front();
				check_field("frame_is_speech", want.speech, frame_is_speech);
				check_field("frame_energy", want.energy, frame_energy);
				check_field("speaking", want.talking, speaking);
				check_field("forward_frame", want.fwd, forward_frame);
				check_field("valid_speech", want.valid, valid_speech);
				check_field("speech_ended", want.ended, speech_ended);
				check_field("session_done", want.done, session_done);
			end
		end
	end

	// watchdog on cycles with no item moving anywhere
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, stalled_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side backpressure
	initial begin
		int gap;
		out_ready <= 1'b0;
		forever begin
			gap = idle_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		int phase, k;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		frame_end <= 1'b0;
		now_ms <= '0;
		session_start <= 1'b0;
		clock_ms = '0;

		// directed part, reset settings
		// fields: sample, frame_end, now_ms, session_start, repeat, typed, result
		// no session start after reset: silent one-sample frame
		add_row(16'sd0, 1, 32'd0, 0, 1, 1, {1'b0, 16'd0, 5'b00000});
		// start and end together, most negative sample, mean at its top
		add_row(16'sh8000, 1, 32'd100, 1, 1, 1, {1'b0, 16'd32768, 5'b00000});
		add_row(16'sd32767, 1, 32'd200, 0, 1, 1, {1'b0, 16'd32767, 5'b00000});
		// high-variance frame starts speech, then hysteresis carries it
		add_row(16'sd0, 0, 32'd300, 0, 1, 0, '0);
		add_row(16'sd32767, 1, 32'd300, 0, 1, 0, '0);
		add_row(16'sd40, 1, 32'd400, 0, 1, 0, '0);
		add_row(16'sd40, 1, 32'd460, 0, 1, 0, '0);
		// silence until the hangover runs out; valid speech ended stops the session
		add_row(16'sd0, 1, 32'd1000, 0, 1, 0, '0);
		add_row(16'sd0, 1, 32'd1460, 0, 1, 1, {1'b0, 16'd0, 5'b01111});
		// dropped after stop
		add_row(16'sd1234, 1, 32'd1500, 0, 1, 0, '0);
		add_row(-16'sd1, 0, 32'd1500, 0, 1, 0, '0);
		// speech across the time stamp wrap
		add_row(16'sd0, 0, 32'hFFFF_FF00, 1, 1, 0, '0);
		add_row(-16'sd32767, 1, 32'hFFFF_FF00, 0, 1, 0, '0);
		add_row(-16'sd20000, 1, 32'h0000_0010, 0, 1, 0, '0);
		// overlong frame closed by the cap
		add_row(-16'sd50, 0, 32'h0000_0020, 0, FRAME_CAP, 0, '0);
		add_row(16'sd29, 1, 32'h0000_0030, 0, 1, 0, '0);
		// energy exactly at threshold, no variance
		add_row(16'sd30, 1, 32'd5000, 1, 1, 0, '0);
		// session start in mid-frame drops the partial frame
		add_row(16'sd7, 0, 32'd6000, 0, 1, 0, '0);
		add_row(16'sd9, 1, 32'd6001, 1, 1, 0, '0);
		add_row(16'sd32767, 0, 32'd7000, 0, 1, 0, '0);
		add_row(16'sh8000, 1, 32'd7000, 0, 1, 0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			for (k = 0; k < script[i].reps; k++)
				send_item(script[i].item, script[i].typed, script[i].want);
		end

		// random part over several register settings
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				settle();
				program_phase(phase);
			end
			random_traffic(RANDOM_ITEMS / PHASES);
		end
		settle();

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
